/* rtl/b32e_pkg.sv */
// Shared types, constants and the digit-to-character function for the base32 encoder.
package b32e_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned SYMBOL_W    = 7;
   localparam int unsigned DIGIT_W     = 5;
   localparam int unsigned GROUP_W     = 40;
   localparam int unsigned PENDING_W   = 32;
   localparam int unsigned COUNT_W     = 3;
   localparam int unsigned NCHARS_W    = 4;
   localparam int unsigned CHAR_IDX_W  = 3;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [DIGIT_W-1:0]    DIGIT_LETTERS = 5'd26;
   localparam logic [SYMBOL_W-1:0]   CHAR_A        = 7'h41;
   localparam logic [SYMBOL_W-1:0]   CHAR_TWO      = 7'h32;
   localparam logic [SYMBOL_W-1:0]   PAD_CHAR      = 7'h3D;
   localparam logic [CHAR_IDX_W-1:0] LAST_CHAR     = 3'd7;

   // One closed group handed from the front to the back.
   typedef struct packed {
      logic [GROUP_W-1:0]  group;
      logic [NCHARS_W-1:0] nchars;
      logic                fin;
   } b32e_group_type;

   // Fill status of the group queue.
   typedef struct packed {
      logic full;
      logic empty;
   } b32e_queue_stat_type;

   // Maps a 5-bit digit onto A-Z then 2-7.
   function automatic logic [SYMBOL_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [SYMBOL_W-1:0] r;
      if (d < DIGIT_LETTERS) begin
         r = CHAR_A + {2'b00, d};
      end else begin
         r = CHAR_TWO + {2'b00, d - DIGIT_LETTERS};
      end
      return r;
   endfunction

endpackage

/* rtl/b32e_chan_if.sv */
// Valid/ready channel interfaces for the encoder's byte input and character output.
interface b32e_req_if import b32e_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic                final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32e_rsp_if import b32e_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                group_end;
   logic                message_end;

   modport source (output valid, output symbol, output group_end, output message_end,
                   input ready);
   modport sink (input valid, input symbol, input group_end, input message_end,
                 output ready);
endinterface

/* rtl/b32e_front.sv */
// Front end: accepts bytes, gathers them into groups and closes a group into the queue.
module b32e_front import b32e_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   b32e_req_if.sink       req_chan,
   input  logic           q_full,
   output logic           q_push,
   output b32e_group_type q_entry
);

   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   total;
   logic                 accept;
   logic                 close;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Count this byte in and decide whether the group closes.
   always_comb begin
      total   = count_ff + 3'd1;
      close   = (total == 3'd5) || req_chan.final_byte;
      q_push  = accept && close;

      // Left-align the held bytes and this byte; zero bits pad the tail.
      q_entry.fin = req_chan.final_byte;
      case (total)
         3'd1: begin
            q_entry.group  = {req_chan.data_byte, 32'd0};
            q_entry.nchars = 4'd2;
         end
         3'd2: begin
            q_entry.group  = {pending_ff[7:0], req_chan.data_byte, 24'd0};
            q_entry.nchars = 4'd4;
         end
         3'd3: begin
            q_entry.group  = {pending_ff[15:0], req_chan.data_byte, 16'd0};
            q_entry.nchars = 4'd5;
         end
         3'd4: begin
            q_entry.group  = {pending_ff[23:0], req_chan.data_byte, 8'd0};
            q_entry.nchars = 4'd7;
         end
         default: begin
            q_entry.group  = {pending_ff, req_chan.data_byte};
            q_entry.nchars = 4'd8;
         end
      endcase

      pending_in = pending_ff;
      count_in   = count_ff;
      if (accept) begin
         if (close) begin
            pending_in = '0;
            count_in   = '0;
         end else begin
            pending_in = {pending_ff[PENDING_W-BYTE_W-1:0], req_chan.data_byte};
            count_in   = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

endmodule

/* rtl/b32e_queue.sv */
// Short queue of closed groups between the front and the back.
module b32e_queue import b32e_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b32e_group_type      push_entry,
   input  logic                pop,
   output b32e_group_type      pop_entry,
   output b32e_queue_stat_type stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   b32e_group_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/b32e_back.sv */
// Back end: turns one queued group into eight characters through an output register.
module b32e_back import b32e_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  b32e_group_type q_entry,
   output logic           q_pop,
   b32e_rsp_if.source     rsp_chan
);

   logic                  busy_ff, busy_in;
   logic [GROUP_W-1:0]    group_ff, group_in;
   logic [NCHARS_W-1:0]   nchars_ff, nchars_in;
   logic                  fin_ff, fin_in;
   logic [CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [SYMBOL_W-1:0]   symbol_ff, symbol_in;
   logic                  group_end_ff, group_end_in;
   logic                  message_end_ff, message_end_in;
   logic                  advance;
   logic                  last;

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.symbol      = symbol_ff;
   assign rsp_chan.group_end   = group_end_ff;
   assign rsp_chan.message_end = message_end_ff;

   // One character leaves per cycle whenever a group is held and the output register is free.
   always_comb begin
      advance = busy_ff && (!valid_ff || rsp_chan.ready);
      last    = (idx_ff == LAST_CHAR);
      q_pop   = q_valid && (!busy_ff || (advance && last));

      valid_in       = valid_ff;
      symbol_in      = symbol_ff;
      group_end_in   = group_end_ff;
      message_end_in = message_end_ff;
      if (advance) begin
         valid_in = 1'b1;
         if ({1'b0, idx_ff} < nchars_ff) begin
            symbol_in = digit_char(group_ff[GROUP_W-1 -: DIGIT_W]);
         end else begin
            symbol_in = PAD_CHAR;
         end
         group_end_in   = last;
         message_end_in = last && fin_ff;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end

      busy_in   = busy_ff;
      group_in  = group_ff;
      nchars_in = nchars_ff;
      fin_in    = fin_ff;
      idx_in    = advance ? idx_ff + 1'b1 : idx_ff;
      if (advance) begin
         group_in = {group_ff[GROUP_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in   = 1'b1;
         group_in  = q_entry.group;
         nchars_in = q_entry.nchars;
         fin_in    = q_entry.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      group_ff       <= group_in;
      nchars_ff      <= nchars_in;
      fin_ff         <= fin_in;
      symbol_ff      <= symbol_in;
      group_end_ff   <= group_end_in;
      message_end_ff <= message_end_in;
   end

endmodule

/* rtl/base32_stream_encoder_unit.sv */
// Streaming base32 encoder: one byte in per item, one ASCII character out per item.
// The byte that closes a group passes through the group queue and the back end's group
// register before its first character reaches the output register; the eight characters
// then follow one per cycle while the sink is ready. Bytes are accepted while the group
// queue is not full.
// Reset is synchronous: it empties the byte gatherer, the group queue and the output.
module base32_stream_encoder_unit import b32e_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   b32e_req_if.sink   req_chan,
   b32e_rsp_if.source rsp_chan
);

   logic                q_push;
   logic                q_pop;
   b32e_group_type      q_in_entry;
   b32e_group_type      q_out_entry;
   b32e_queue_stat_type q_stat;

   // Byte gathering and group closing.
   b32e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_stat.full),
      .q_push   (q_push),
      .q_entry  (q_in_entry)
   );

   // Group queue.
   b32e_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .pop_entry  (q_out_entry),
      .stat       (q_stat)
   );

   // Character generation.
   b32e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (!q_stat.empty),
      .q_entry  (q_out_entry),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // The message end mark only ever falls on the last character of a group.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.message_end |-> rsp_chan.group_end)
      else $error("message end without group end");

   // The queue is never written while full.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("group queue overflow");

   // The queue is never read while empty.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("group queue underflow");

   // No character is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("output valid after reset");

endmodule
